FILE: rtl/core/mvna_pkg.sv
package mvna_pkg;

	localparam int POS_W  = 16;
	localparam int ACC_W  = 24;
	localparam int NRM_W  = 16;
	localparam int CROSS_W = 36;
	localparam int ONE_Q14 = 16384;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_TRI   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [9:0]  vertex_index;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [9:0]  corner_a;
		logic [9:0]  corner_b;
		logic [9:0]  corner_c;
	} req_t;

	typedef struct packed {
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
		logic        status;
	} rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic        bad;
		logic [9:0]  vertex_index;
		logic [47:0] pos;
		logic [9:0]  corner_a;
		logic [9:0]  corner_b;
		logic [9:0]  corner_c;
	} cmd_t;

endpackage

FILE: rtl/core/mvna_if.sv
interface mvna_req_if import mvna_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mvna_rsp_if import mvna_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/mvna_front.sv
module mvna_front import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mvna_req_if.sink    req,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	localparam int QD = 2;

	logic [10:0] vcount_q;
	logic [16:0] lim;
	cmd_t        fifo_q [QD];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	cmd_t        c;
	logic        push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= '0;
		else if (cfg_we) vcount_q <= cfg_wdata;
	end

	always_comb begin
		lim = (17'(vcount_q) < 17'(MAX_VERTICES)) ? 17'(vcount_q) : 17'(MAX_VERTICES);
		c.op = op_t'(req.payload.op);
		c.vertex_index = req.payload.vertex_index;
		c.pos = {req.payload.pos_x, req.payload.pos_y, req.payload.pos_z};
		c.corner_a = req.payload.corner_a;
		c.corner_b = req.payload.corner_b;
		c.corner_c = req.payload.corner_c;
		case (c.op)
			OP_CLEAR: c.bad = 1'b0;
			OP_TRI: c.bad = (17'(c.corner_a) >= lim) || (17'(c.corner_b) >= lim)
				|| (17'(c.corner_c) >= lim);
			default: c.bad = 17'(c.vertex_index) >= lim;
		endcase
	end

	assign req.ready = cnt_q != 2'(QD);
	assign push = req.valid && req.ready;
	assign cmd_valid = cnt_q != '0;
	assign pop = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rp_q];

	always_ff @(posedge clk) if (push) fifo_q[wp_q] <= c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QD))
		else $error("queue overflow");
	a_nopush_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QD) |-> !push) else $error("push when full");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop when empty");
endmodule

FILE: rtl/core/mvna_norm.sv
module mvna_norm import mvna_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [CROSS_W-1:0] cx,
	input  logic signed [CROSS_W-1:0] cy,
	input  logic signed [CROSS_W-1:0] cz,
	output logic                      done,
	output logic signed [NRM_W-1:0]   nx,
	output logic signed [NRM_W-1:0]   ny,
	output logic signed [NRM_W-1:0]   nz
);
	typedef enum logic [6:0] {
		N_IDLE  = 7'b0000001,
		N_SHIFT = 7'b0000010,
		N_SQ    = 7'b0000100,
		N_ROOT  = 7'b0001000,
		N_DIV   = 7'b0010000,
		N_FIN   = 7'b0100000,
		N_DONE  = 7'b1000000
	} nst_t;

	nst_t             st_q;
	logic [35:0]      u_q [3];
	logic [2:0]       neg_q;
	logic [43:0]      s_q;
	logic [43:0]      res_q;
	logic [43:0]      bit_q;
	logic [1:0]       sq_i_q, dv_i_q;
	logic [35:0]      rem_q;
	logic [34:0]      quo_q;
	logic [5:0]       dcnt_q;
	logic [14:0]      q_q [3];
	logic [35:0]      m;
	logic [43:0]      sqv;
	logic [43:0]      rb;
	logic [36:0]      trial;
	logic [35:0]      num;
	logic [22:0]      lenr;

	function automatic logic [35:0] mag(input logic signed [35:0] v);
		return v[35] ? 36'(-v) : 36'(v);
	endfunction

	always_comb begin
		m = u_q[0];
		if (u_q[1] > m) m = u_q[1];
		if (u_q[2] > m) m = u_q[2];
		sqv = 44'(u_q[sq_i_q][20:0]) * 44'(u_q[sq_i_q][20:0]);
		rb = res_q + bit_q;
		// dividend carries the rounding term
		num = (36'(u_q[dv_i_q]) << 14) + 36'(res_q >> 1);
		trial = {rem_q, num[6'd35 - dcnt_q]};
		lenr = {1'b0, res_q[21:0]};
	end

	assign done = st_q == N_DONE;
	assign nx = neg_q[0] ? -NRM_W'(q_q[0]) : NRM_W'(q_q[0]);
	assign ny = neg_q[1] ? -NRM_W'(q_q[1]) : NRM_W'(q_q[1]);
	assign nz = neg_q[2] ? -NRM_W'(q_q[2]) : NRM_W'(q_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			case (st_q)
				N_IDLE: if (start) begin
					u_q[0] <= mag(cx); u_q[1] <= mag(cy); u_q[2] <= mag(cz);
					neg_q <= {cz[35], cy[35], cx[35]};
					st_q <= N_SHIFT;
				end
				N_SHIFT: begin
					// bring the largest magnitude into [2^19, 2^20)
					if (m == '0) begin
						q_q[0] <= '0; q_q[1] <= '0; q_q[2] <= '0;
						st_q <= N_DONE;
					end else if (m >= 36'(1 << 20)) begin
						for (int i = 0; i < 3; i++) u_q[i] <= u_q[i] >> 1;
					end else if (m < 36'(1 << 19)) begin
						for (int i = 0; i < 3; i++) u_q[i] <= u_q[i] << 1;
					end else begin
						s_q <= '0; sq_i_q <= '0; st_q <= N_SQ;
					end
				end
				N_SQ: begin
					s_q <= s_q + sqv;
					if (sq_i_q == 2'd2) begin
						res_q <= '0; bit_q <= 44'd1 << 42; st_q <= N_ROOT;
					end
					sq_i_q <= sq_i_q + 2'd1;
				end
				N_ROOT: begin
					if (s_q >= rb) begin
						s_q <= s_q - rb;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 44'd1) begin
						dv_i_q <= '0; st_q <= N_FIN;
					end
				end
				N_FIN: begin
					// restoring divide over the 36 dividend bits
					rem_q <= '0;
					quo_q <= '0; dcnt_q <= '0; st_q <= N_DIV;
				end
				N_DIV: begin
					if (trial >= 37'(lenr)) begin
						rem_q <= 36'(trial - 37'(lenr));
						quo_q <= {quo_q[33:0], 1'b1};
					end else begin
						rem_q <= 36'(trial);
						quo_q <= {quo_q[33:0], 1'b0};
					end
					if (dcnt_q == 6'd35) begin
						st_q <= (dv_i_q == 2'd2) ? N_DONE : N_FIN;
						dv_i_q <= dv_i_q + 2'd1;
					end
					dcnt_q <= dcnt_q + 6'd1;
				end
				N_DONE: st_q <= N_IDLE;
				default: st_q <= N_IDLE;
			endcase
			if (st_q == N_DIV && dcnt_q == 6'd35) begin
				q_q[dv_i_q] <= ({quo_q[33:0], (trial >= 37'(lenr))} > 35'(ONE_Q14))
					? 15'(ONE_Q14) : 15'({quo_q[33:0], (trial >= 37'(lenr))});
			end
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> st_q == N_IDLE) else $error("done not single cycle");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == N_DIV |-> res_q != '0) else $error("zero length divide");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> q_q[0] <= 15'(ONE_Q14)) else $error("normal over one");
endmodule

FILE: rtl/core/mvna_back.sv
module mvna_back import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	mvna_rsp_if.source  rsp
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	typedef enum logic [11:0] {
		B_IDLE  = 12'b000000000001,
		B_CLR   = 12'b000000000010,
		B_PRD   = 12'b000000000100,
		B_PWT   = 12'b000000001000,
		B_CROSS = 12'b000000010000,
		B_MUL   = 12'b000000100000,
		B_NORM  = 12'b000001000000,
		B_ARD   = 12'b000010000000,
		B_AWT   = 12'b000100000000,
		B_AWR   = 12'b001000000000,
		B_OUT   = 12'b010000000000,
		B_RWT   = 12'b100000000000
	} bst_t;

	bst_t               st_q;
	cmd_t               c_q;
	logic [47:0]        pmem [MAX_VERTICES];
	logic [71:0]        amem [MAX_VERTICES];
	logic [47:0]        prd_q;
	logic [71:0]        ard_q;
	logic [AW:0]        clr_q;
	logic [1:0]         k_q;
	logic [47:0]        pa_q, pb_q;
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [CROSS_W-1:0] p_q [6];
	logic signed [CROSS_W-1:0] cr_q [3];
	logic [2:0]         mi_q;
	logic               nstart_q;
	logic               is_read_q;
	logic               ndone;
	logic signed [NRM_W-1:0] nx, ny, nz;
	logic signed [NRM_W-1:0] fn_q [3];
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      kaddr;
	logic               out_v_q;
	rsp_t               out_q;
	logic signed [16:0] ma, mb;
	logic [71:0]        wsum;

	function automatic logic signed [16:0] pc(input logic [47:0] p, input int i);
		return 17'(signed'(p[47-16*i -: 16]));
	endfunction

	function automatic logic [23:0] sat(input logic [23:0] a, input logic signed [15:0] b);
		logic signed [24:0] r;
		r = 25'(signed'(a)) + 25'(b);
		if (r > 25'sd8388607) return 24'h7FFFFF;
		if (r < -25'sd8388608) return 24'h800000;
		return r[23:0];
	endfunction

	always_comb begin
		case (k_q)
			2'd0: kaddr = AW'(c_q.corner_a);
			2'd1: kaddr = AW'(c_q.corner_b);
			default: kaddr = AW'(c_q.corner_c);
		endcase
		raddr = (c_q.op == OP_READ) ? AW'(c_q.vertex_index) : kaddr;
		case (mi_q)
			3'd0: begin ma = e1_q[1]; mb = e2_q[2]; end
			3'd1: begin ma = e1_q[2]; mb = e2_q[1]; end
			3'd2: begin ma = e1_q[2]; mb = e2_q[0]; end
			3'd3: begin ma = e1_q[0]; mb = e2_q[2]; end
			3'd4: begin ma = e1_q[0]; mb = e2_q[1]; end
			default: begin ma = e1_q[1]; mb = e2_q[0]; end
		endcase
		wsum = {sat(ard_q[71:48], fn_q[0]), sat(ard_q[47:24], fn_q[1]),
			sat(ard_q[23:0], fn_q[2])};
	end

	always_ff @(posedge clk) begin
		prd_q <= pmem[kaddr];
		ard_q <= amem[raddr];
		if (st_q == B_IDLE && cmd_valid && cmd.op == OP_WRITE && !cmd.bad)
			pmem[AW'(cmd.vertex_index)] <= cmd.pos;
		if (st_q == B_CLR) amem[clr_q[AW-1:0]] <= '0;
		else if (st_q == B_AWR) amem[kaddr] <= wsum;
	end

	mvna_norm u_norm (
		.clk, .arst_n, .start(nstart_q),
		.cx(is_read_q ? CROSS_W'(signed'(ard_q[71:48])) : cr_q[0]),
		.cy(is_read_q ? CROSS_W'(signed'(ard_q[47:24])) : cr_q[1]),
		.cz(is_read_q ? CROSS_W'(signed'(ard_q[23:0])) : cr_q[2]),
		.done(ndone), .nx, .ny, .nz
	);

	assign cmd_ready = st_q == B_IDLE && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_CLR; clr_q <= '0; out_v_q <= 1'b0; nstart_q <= 1'b0;
		end else begin
			nstart_q <= st_q == B_ARD && (is_read_q || mi_q != 3'd6);
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			case (st_q)
				B_IDLE: if (cmd_valid && cmd_ready) begin
					c_q <= cmd; k_q <= '0; is_read_q <= cmd.op == OP_READ;
					if (cmd.bad) begin
						out_q <= '{default: '0, status: 1'b1};
						out_v_q <= 1'b1;
					end else case (cmd.op)
						OP_CLEAR: begin clr_q <= '0; st_q <= B_CLR; end
						OP_TRI: st_q <= B_PRD;
						OP_READ: st_q <= B_RWT;
						default: st_q <= B_IDLE;
					endcase
				end
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_VERTICES - 1)) st_q <= B_IDLE;
				end
				B_PRD: st_q <= B_PWT;
				B_PWT: begin
					// positions are read one corner at a time, each through B_PRD then B_PWT
					if (k_q == 2'd0) pa_q <= prd_q;
					else if (k_q == 2'd1) pb_q <= prd_q;
					else begin
						for (int i = 0; i < 3; i++) begin
							e1_q[i] <= pc(pb_q, i) - pc(pa_q, i);
							e2_q[i] <= pc(prd_q, i) - pc(pa_q, i);
						end
					end
					k_q <= k_q + 2'd1;
					st_q <= (k_q == 2'd2) ? B_CROSS : B_PRD;
				end
				B_CROSS: begin mi_q <= '0; st_q <= B_MUL; end
				B_MUL: begin
					p_q[mi_q] <= CROSS_W'(ma * mb);
					mi_q <= mi_q + 3'd1;
					if (mi_q == 3'd5) st_q <= B_ARD;
				end
				B_ARD: begin
					if (!is_read_q && mi_q == 3'd6) begin
						cr_q[0] <= p_q[0] - p_q[1];
						cr_q[1] <= p_q[2] - p_q[3];
						cr_q[2] <= p_q[4] - p_q[5];
						mi_q <= '0;
					end else begin
						st_q <= B_NORM;
					end
				end
				B_RWT: st_q <= B_ARD;
				B_NORM: if (ndone) begin
					if (is_read_q) begin
						out_q <= '{normal_x: nx, normal_y: ny, normal_z: nz, status: 1'b0};
						out_v_q <= 1'b1;
						st_q <= B_IDLE;
					end else begin
						fn_q[0] <= nx; fn_q[1] <= ny; fn_q[2] <= nz;
						k_q <= '0; st_q <= B_AWT;
					end
				end
				B_AWT: st_q <= B_OUT;
				B_OUT: st_q <= B_AWR;
				B_AWR: begin
					k_q <= k_q + 2'd1;
					st_q <= (k_q == 2'd2) ? B_IDLE : B_AWT;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !rsp.ready |=> out_v_q) else $error("response dropped");
	a_clr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_CLR |-> clr_q < (AW+1)'(MAX_VERTICES)) else $error("clear overrun");
	a_norm_start: assert property (@(posedge clk) disable iff (!arst_n)
		nstart_q |-> $past(st_q) == B_ARD) else $error("stray normalize start");
endmodule

FILE: rtl/core/mesh_vertex_normal_accumulator_core.sv
// channel | dir | payload                                    | handshake
// req     | in  | op, vertex_index, pos_x/y/z, corner_a/b/c  | valid/ready
// rsp     | out | normal_x/y/z, status                       | valid/ready
// cfg     | in  | cfg_wdata (vertex_count)                   | cfg_we
// a position write needs no normalize; reads and triangles pass through the
// normalize unit (magnitude shifts, bit-serial root and three restoring divides
// over 36 dividend bits), which dominates; a zero vector skips most of it.
// after reset and after each clear request all MAX_VERTICES accumulators are
// swept to zero while the execution side takes no command.
// a two-entry queue decouples request intake from the execution side.
module mesh_vertex_normal_accumulator_core import mvna_pkg::*; #(
	parameter int MAX_VERTICES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mvna_req_if.sink    req,
	mvna_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	mvna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk, .arst_n, .req, .cfg_we, .cfg_wdata, .cmd_valid, .cmd_ready, .cmd
	);

	mvna_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .rsp
	);
endmodule
